FILE: sv/wildcard_flow_table_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the flow table unit
// Shared macro forms for the concurrent checks.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_FLOW_TABLE_UNIT_ASSERT_SVH
`define WILDCARD_FLOW_TABLE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define WFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: sv/wft_pkg.sv
// ---------------------------------------------------------------------------
// Flow table package
// Widths, command and status codes shared by the flow table files.
// ---------------------------------------------------------------------------
package wft_pkg;
	localparam int unsigned Capacity = 64;
	localparam int unsigned IdxW = $clog2(Capacity);
	localparam int unsigned CntW = $clog2(Capacity + 1);

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_MODIFY = 3'd1;
	localparam logic [2:0] CMD_FIND = 3'd2;
	localparam logic [2:0] CMD_CONSUME = 3'd3;
	localparam logic [2:0] CMD_DELETE = 3'd4;
	localparam logic [2:0] CMD_EXPIRE = 3'd5;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EXISTS = 3'd1;
	localparam logic [2:0] ST_DENIED = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;
	localparam logic [0:0] REG_TIMEOUT = 1'b0;

	typedef struct packed {
		logic [2:0] cmd;
		logic is_v6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [15:0] port;
		logic [7:0] proto;
		logic port_given;
		logic proto_given;
		logic one_shot;
		logic owns_port;
		logic [47:0] payload_in;
		logic [63:0] now_time;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [47:0] payload_out;
		logic [15:0] freed_port;
		logic free_tcp;
		logic free_udp;
		logic last;
	} rsp_t;

	// Flags: bit 0 port given, 1 proto given, 2 one shot, 3 owns port, 4 IPv6.
	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [15:0] port;
		logic [7:0] proto;
		logic [4:0] flags;
		logic [47:0] payload;
		logic [63:0] deadline;
	} slot_t;
endpackage

FILE: sv/wft_if.sv
// ---------------------------------------------------------------------------
// Flow table channel interfaces
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface wft_req_if;
	import wft_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wft_rsp_if;
	import wft_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/wildcard_flow_table_unit.sv
// ---------------------------------------------------------------------------
// Wildcard flow table unit
// Flow table with wildcard port/protocol match, exact-key upsert and aging.
// ---------------------------------------------------------------------------
// Channel   Direction  Content
// req       sink       one command item (cmd, key, flags, payload, time)
// rsp       source     result items, last marks the final one of a command
// apb       slave      timeout_us at address 0
//
// Each command scans the slot memory once, one slot per cycle over a shared
// compare unit unless a pending removal item holds it. The decision, the
// re-read of the hit slot, the table write and the result follow the scan.
// In an expire, every removal item but the final one holds the scan until it
// is taken.
// Reset clears the used bits and sets timeout_us to 2000000.
// In an expire a stalled result holds the scan; no new command is taken until the last
// result item of the current one has been accepted.
module wildcard_flow_table_unit (
	input  logic clk,
	input  logic arst_n,
	wft_req_if.sink req,
	wft_rsp_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import wft_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;
	localparam logic [2:0] S_XOUT = 3'd6;

	logic [2:0] state_q;
	logic [31:0] timeout_q;
	req_t cmd_q;
	logic [Capacity-1:0] used_q;
	slot_t mem [Capacity];
	slot_t rd_q;
	logic [IdxW-1:0] rd_idx_q;
	logic rd_vld_q;
	logic [CntW-1:0] scan_q;
	logic wild_hit_q, exact_hit_q, free_hit_q;
	logic [IdxW-1:0] wild_idx_q, exact_idx_q, free_idx_q;
	logic [IdxW-1:0] act_idx_q;
	slot_t wr_q;
	logic wr_en_q;
	logic [IdxW-1:0] wr_idx_q;
	rsp_t rsp_q;
	logic rsp_vld_q;
	// An expire holds back its latest removal item, as only the end of the
	// scan shows whether it is the final one.
	rsp_t xbuf_q;
	logic xany_q;
	logic [63:0] deadline_q;

	// Key as stored: IPv4 drops the upper address bits, wildcards force zero.
	logic [63:0] k_hi, k_lo;
	logic [15:0] k_port;
	logic [7:0] k_proto;
	logic [1:0] k_flags;
	assign k_hi = cmd_q.is_v6 ? cmd_q.addr_hi : 64'd0;
	assign k_lo = cmd_q.is_v6 ? cmd_q.addr_lo : {32'd0, cmd_q.addr_lo[31:0]};
	assign k_port = cmd_q.port_given ? cmd_q.port : 16'd0;
	assign k_proto = cmd_q.proto_given ? cmd_q.proto : 8'd0;
	assign k_flags = {cmd_q.proto_given, cmd_q.port_given};

	// Shared compare unit on the registered slot word.
	logic same_addr, wild_m, exact_m, expired;
	logic [15:0] wport;
	logic [7:0] wproto;
	always_comb begin
		same_addr = (rd_q.flags[4] == cmd_q.is_v6) && rd_q.addr_hi == k_hi
			&& rd_q.addr_lo == k_lo;
		// Add matches against the stored key; find and consume use the query.
		wport = (cmd_q.cmd == CMD_ADD) ? k_port : cmd_q.port;
		wproto = (cmd_q.cmd == CMD_ADD) ? k_proto : cmd_q.proto;
		wild_m = same_addr && (!rd_q.flags[0] || rd_q.port == wport)
			&& (!rd_q.flags[1] || rd_q.proto == wproto);
		exact_m = same_addr && rd_q.port == k_port && rd_q.proto == k_proto
			&& rd_q.flags[1:0] == k_flags;
		expired = rd_q.deadline <= cmd_q.now_time;
	end

	// Release fields for removal of the slot in rd_q / act slot.
	function automatic rsp_t rel(input slot_t s, input logic [15:0] p);
		rsp_t r;
		r = '0;
		if (s.flags[3]) begin
			if (!s.flags[1]) begin
				r.free_tcp = 1'b1;
				r.free_udp = 1'b1;
				r.freed_port = p;
			end else if (s.proto == PROTO_TCP) begin
				r.free_tcp = 1'b1;
				r.freed_port = p;
			end else if (s.proto == PROTO_UDP) begin
				r.free_udp = 1'b1;
				r.freed_port = p;
			end
		end
		return r;
	endfunction

	logic [64:0] dl_sum;
	assign dl_sum = {1'b0, cmd_q.now_time} + {33'd0, timeout_q};

	logic scan_done;
	assign scan_done = scan_q == CntW'(Capacity);
	logic rd_go;
	// In expire, the scan waits while the output register still holds an item.
	assign rd_go = !(cmd_q.cmd == CMD_EXPIRE && rsp_vld_q);

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data = rsp_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_q : 32'd0;

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !scan_done && rd_go)
			rd_q <= mem[scan_q[IdxW-1:0]];
		else if (state_q == S_CHECK)
			rd_q <= mem[act_idx_q];
		if (wr_en_q)
			mem[wr_idx_q] <= wr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			timeout_q <= TIMEOUT_RESET;
			used_q <= '0;
			rsp_vld_q <= 1'b0;
			rd_vld_q <= 1'b0;
			wr_en_q <= 1'b0;
			scan_q <= '0;
		end else begin
			wr_en_q <= 1'b0;
			if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
				timeout_q <= pwdata;
			if (rsp_vld_q && rsp.ready)
				rsp_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.data;
						scan_q <= '0;
						rd_vld_q <= 1'b0;
						wild_hit_q <= 1'b0;
						exact_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						xany_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					deadline_q <= dl_sum[64] ? '1 : dl_sum[63:0];
					if (rd_go) begin
						// Evaluate the slot word registered in rd_q by the last scan step.
						if (rd_vld_q) begin
							if (!used_q[rd_idx_q]) begin
								if (!free_hit_q) begin
									free_hit_q <= 1'b1;
									free_idx_q <= rd_idx_q;
								end
							end else begin
								if (wild_m && !wild_hit_q) begin
									wild_hit_q <= 1'b1;
									wild_idx_q <= rd_idx_q;
								end
								if (exact_m && !exact_hit_q) begin
									exact_hit_q <= 1'b1;
									exact_idx_q <= rd_idx_q;
								end
								if (cmd_q.cmd == CMD_EXPIRE && expired) begin
									used_q[rd_idx_q] <= 1'b0;
									xbuf_q <= rel(rd_q, rd_q.port);
									xany_q <= 1'b1;
									// The removal held back is not the final one.
									if (xany_q) begin
										rsp_q <= xbuf_q;
										rsp_vld_q <= 1'b1;
									end
								end
							end
						end
						rd_vld_q <= !scan_done;
						rd_idx_q <= scan_q[IdxW-1:0];
						if (!scan_done)
							scan_q <= scan_q + 1'b1;
						else
							state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// An expire may still be showing a removal item here.
					if (cmd_q.cmd != CMD_EXPIRE) begin
						rsp_q <= '0;
						rsp_q.last <= 1'b1;
					end
					state_q <= S_OUT;
					case (cmd_q.cmd)
						CMD_EXPIRE: state_q <= S_XOUT;
						CMD_ADD: begin
							if (wild_hit_q)
								rsp_q.status <= ST_EXISTS;
							else if (!free_hit_q)
								rsp_q.status <= ST_FULL;
							else
								state_q <= S_WRITE;
						end
						CMD_MODIFY: begin
							if (exact_hit_q) begin
								act_idx_q <= exact_idx_q;
								state_q <= S_CHECK;
							end else if (!free_hit_q)
								rsp_q.status <= ST_FULL;
							else
								state_q <= S_WRITE;
						end
						CMD_FIND, CMD_CONSUME: begin
							if (!wild_hit_q)
								rsp_q.status <= ST_NOT_FOUND;
							else begin
								act_idx_q <= wild_idx_q;
								state_q <= S_CHECK;
							end
						end
						CMD_DELETE: begin
							if (!exact_hit_q)
								rsp_q.status <= ST_NOT_FOUND;
							else begin
								act_idx_q <= exact_idx_q;
								state_q <= S_CHECK;
							end
						end
						default: ;
					endcase
				end
				S_CHECK: state_q <= S_WRITE;
				S_WRITE: begin
					state_q <= S_OUT;
					case (cmd_q.cmd)
						CMD_ADD, CMD_MODIFY: begin
							if (cmd_q.cmd == CMD_MODIFY && exact_hit_q) begin
								if (rd_q.flags[3] != cmd_q.owns_port)
									rsp_q.status <= ST_DENIED;
								else begin
									wr_q <= rd_q;
									wr_q.flags[2] <= cmd_q.one_shot;
									wr_q.payload <= cmd_q.payload_in;
									wr_q.deadline <= deadline_q;
									wr_idx_q <= act_idx_q;
									wr_en_q <= 1'b1;
								end
							end else begin
								wr_q <= '{addr_hi: k_hi, addr_lo: k_lo, port: k_port,
									proto: k_proto,
									flags: {cmd_q.is_v6, cmd_q.owns_port, cmd_q.one_shot,
										k_flags},
									payload: cmd_q.payload_in, deadline: deadline_q};
								wr_idx_q <= free_idx_q;
								wr_en_q <= 1'b1;
								used_q[free_idx_q] <= 1'b1;
							end
						end
						CMD_FIND: rsp_q.payload_out <= rd_q.payload;
						CMD_CONSUME: begin
							rsp_q.payload_out <= rd_q.payload;
							if (rd_q.flags[2]) begin
								used_q[act_idx_q] <= 1'b0;
								rsp_q.freed_port <= rel(rd_q, cmd_q.port).freed_port;
								rsp_q.free_tcp <= rel(rd_q, cmd_q.port).free_tcp;
								rsp_q.free_udp <= rel(rd_q, cmd_q.port).free_udp;
							end
						end
						default: begin
							used_q[act_idx_q] <= 1'b0;
							rsp_q.freed_port <= rel(rd_q, rd_q.port).freed_port;
							rsp_q.free_tcp <= rel(rd_q, rd_q.port).free_tcp;
							rsp_q.free_udp <= rel(rd_q, rd_q.port).free_udp;
						end
					endcase
				end
				S_OUT: begin
					rsp_vld_q <= 1'b1;
					state_q <= S_XOUT;
				end
				S_XOUT: begin
					// The final item of an expire: the held-back removal, or an
					// empty item when nothing was removed.
					if (cmd_q.cmd == CMD_EXPIRE && !rsp_vld_q) begin
						rsp_q <= xany_q ? xbuf_q : '0;
						rsp_q.last <= 1'b1;
						rsp_vld_q <= 1'b1;
						cmd_q.cmd <= CMD_ADD;
					end else if (!rsp_vld_q || (rsp.ready && rsp_q.last))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/wft_checker.sv
// ---------------------------------------------------------------------------
// Flow table port checker
// Port-level checks of the command and result channels.
// ---------------------------------------------------------------------------
`include "wildcard_flow_table_unit_assert.svh"
module wft_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] rsp_status,
	input logic rsp_last
);
	`WFT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`WFT_ASSERT_IMP(a_no_accept_with_result, clk, arst_n, rsp_valid, !req_ready)
	`WFT_ASSERT_IMP(a_status_range, clk, arst_n, rsp_valid, rsp_status <= 3'd4)
	`WFT_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_last))
endmodule

bind wildcard_flow_table_unit wft_checker u_wft_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
	.rsp_last(rsp.data.last)
);
